>>> rtl/postfix_expression_evaluator_defines.svh
// Assertion macros shared by the postfix expression evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("postfix evaluator assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("postfix evaluator assertion failed");

`endif

>>> rtl/pfx_pkg.sv
// Types, codes and constants shared by the postfix expression evaluator.
`default_nettype none
package pfx_pkg;

  localparam int WORD_W          = 32;
  localparam int STEP_W          = $clog2(WORD_W + 1);
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_ADDSUB,
    AL_ABS_N,
    AL_ABS_D,
    AL_ITER,
    AL_SIGN
  } alu_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

>>> rtl/pfx_stack.sv
// Operand stack memory with one write port and one registered read port.
`default_nettype none
module pfx_stack #(
  parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [pfx_pkg::WORD_W-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [pfx_pkg::WORD_W-1:0]           rdata
);
  import pfx_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pfx_alu.sv
// Shared arithmetic unit: one adder reused for add, subtract, shift-add multiply and divide.
`default_nettype none
module pfx_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  pfx_pkg::alu_req_t          req,
  input  logic [pfx_pkg::WORD_W-1:0] opnd_a,
  input  logic [pfx_pkg::WORD_W-1:0] opnd_b,
  output pfx_pkg::alu_rsp_t          rsp
);
  import pfx_pkg::*;

  alu_state_t        state;
  alu_state_t        state_next;
  alu_op_t           op_r;
  logic [STEP_W-1:0] cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic              neg;
  logic [WORD_W-1:0] res;
  logic              done;

  logic [WORD_W:0]   add_a;
  logic [WORD_W:0]   add_b;
  logic              add_inv;
  logic [WORD_W:0]   sum;
  logic              last_step;

  assign sum       = add_a + (add_inv ? ~add_b : add_b) + {{WORD_W{1'b0}}, add_inv};
  assign last_step = (cnt == STEP_W'(1));
  assign rsp.done  = done;
  assign rsp.res   = res;

  always_comb begin
    state_next = state;
    unique case (state)
      AL_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD, OP_SUB: state_next = AL_ADDSUB;
            OP_MUL:         state_next = AL_ITER;
            OP_DIV:         state_next = AL_ABS_N;
            default:        state_next = AL_IDLE;
          endcase
        end
      end
      AL_ADDSUB: state_next = AL_IDLE;
      AL_ABS_N:  state_next = AL_ABS_D;
      AL_ABS_D:  state_next = AL_ITER;
      AL_ITER: begin
        if (last_step) begin
          state_next = (op_r == OP_DIV) ? AL_SIGN : AL_IDLE;
        end
      end
      AL_SIGN:   state_next = AL_IDLE;
      default:   state_next = AL_IDLE;
    endcase
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_inv = 1'b0;
    unique case (state)
      AL_ADDSUB: begin
        add_a   = {1'b0, x};
        add_b   = {1'b0, y};
        add_inv = (op_r == OP_SUB);
      end
      AL_ABS_N: begin
        add_b   = {1'b0, x};
        add_inv = x[WORD_W-1];
      end
      AL_ABS_D: begin
        add_b   = {1'b0, y};
        add_inv = y[WORD_W-1];
      end
      AL_ITER: begin
        if (op_r == OP_DIV) begin
          add_a   = {acc, x[WORD_W-1]};
          add_b   = {1'b0, y};
          add_inv = 1'b1;
        end else begin
          add_a   = {1'b0, acc};
          add_b   = x[0] ? {1'b0, y} : '0;
        end
      end
      AL_SIGN: begin
        add_b   = {1'b0, x};
        add_inv = neg;
      end
      default: begin
        add_a   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == AL_ADDSUB) || (state == AL_SIGN) ||
                ((state == AL_ITER) && last_step && (op_r == OP_MUL)));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      AL_IDLE: begin
        if (req.start) begin
          op_r <= req.op;
          x    <= opnd_b;
          y    <= opnd_a;
          neg  <= opnd_a[WORD_W-1] ^ opnd_b[WORD_W-1];
          acc  <= '0;
          cnt  <= STEP_W'(WORD_W);
        end
      end
      AL_ADDSUB: res <= sum[WORD_W-1:0];
      AL_ABS_N:  x   <= sum[WORD_W-1:0];
      AL_ABS_D:  y   <= sum[WORD_W-1:0];
      AL_ITER: begin
        cnt <= cnt - STEP_W'(1);
        if (op_r == OP_DIV) begin
          acc <= sum[WORD_W] ? add_a[WORD_W-1:0] : sum[WORD_W-1:0];
          x   <= {x[WORD_W-2:0], ~sum[WORD_W]};
        end else begin
          acc <= sum[WORD_W-1:0];
          x   <= {1'b0, x[WORD_W-1:1]};
          y   <= {y[WORD_W-2:0], 1'b0};
          if (last_step) begin
            res <= sum[WORD_W-1:0];
          end
        end
      end
      AL_SIGN:   res <= sum[WORD_W-1:0];
      default: begin
        res <= res;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: sequencer, stack pointer and result register.
// Each transfer carries one character of a postfix expression; digits are pushed, and the
// operators + - * / pop two values and push the result with 32-bit wrap, division truncating
// toward zero. Every item yields one result with the new top of stack (zero when empty), a
// status code and the final-result flag; an item marked last empties the stack after its
// result. A digit or any error skips the ALU; an operator loads it and waits for its
// result. Multiply and divide run the 32-step shift-add and shift-subtract loop of the
// single shared adder, which handles one bit per cycle. One item is in work at a time, and a
// new item can be taken while the previous result still waits in the output register.
`default_nettype none
`include "postfix_expression_evaluator_defines.svh"
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        symbol,
  input  logic                              end_of_expr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pfx_pkg::WORD_W-1:0] top_value,
  output logic [2:0]                        status,
  output logic                              final_res
);
  import pfx_pkg::*;

  localparam int               IDX_W   = $clog2(STACK_DEPTH);
  localparam int               CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] top_val;
  alu_op_t           cur_op;
  status_t           pend_status;
  logic              pend_last;

  logic              is_digit;
  logic              is_op;
  alu_op_t           dec_op;
  logic [WORD_W-1:0] digit_val;
  logic              go_load;
  logic              accept;
  logic              out_free;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  below_idx;
  logic [CNT_W-1:0]  below_cnt;
  logic [WORD_W-1:0] mem_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  pfx_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (below_idx),
    .rdata (mem_rdata)
  );

  pfx_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opnd_a (top_val),
    .opnd_b (mem_rdata),
    .rsp    (alu_rsp)
  );

  always_comb begin
    is_op  = 1'b1;
    dec_op = OP_ADD;
    case (symbol)
      CH_PLUS:  dec_op = OP_ADD;
      CH_MINUS: dec_op = OP_SUB;
      CH_STAR:  dec_op = OP_MUL;
      CH_SLASH: dec_op = OP_DIV;
      default:  is_op  = 1'b0;
    endcase
  end

  assign is_digit  = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
  assign digit_val = WORD_W'(symbol - CH_ZERO);
  assign below_cnt = cnt - TWO_C;
  assign below_idx = below_cnt[IDX_W-1:0];
  assign go_load   = is_op && (cnt >= TWO_C) && !((dec_op == OP_DIV) && (top_val == '0));
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = go_load ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_next = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt[IDX_W-1:0];
    mem_wdata     = digit_val;
    alu_req.start = 1'b0;
    alu_req.op    = cur_op;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_valid && is_digit && (cnt != DEPTH_C);
      end
      S_LOAD: alu_req.start = 1'b1;
      S_WAIT: begin
        mem_we    = alu_rsp.done;
        mem_waddr = below_idx;
        mem_wdata = alu_rsp.res;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_digit && (cnt != DEPTH_C)) begin
        cnt <= cnt + CNT_W'(1);
      end else if ((state == S_WAIT) && alu_rsp.done) begin
        cnt <= cnt - CNT_W'(1);
      end else if ((state == S_DONE) && out_free && pend_last) begin
        cnt <= '0;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last <= end_of_expr;
      cur_op    <= dec_op;
      if (is_digit) begin
        if (cnt == DEPTH_C) begin
          pend_status <= ST_OVERFLOW;
        end else begin
          pend_status <= ST_OK;
          top_val     <= digit_val;
        end
      end else if (is_op) begin
        if (cnt < TWO_C) begin
          pend_status <= ST_UNDERFLOW;
        end else if (!go_load) begin
          pend_status <= ST_DIVZERO;
        end else begin
          pend_status <= ST_OK;
        end
      end else begin
        pend_status <= ST_INVALID;
      end
    end
    if ((state == S_WAIT) && alu_rsp.done) begin
      top_val <= alu_rsp.res;
    end
    if ((state == S_DONE) && out_free) begin
      top_value <= (cnt == '0) ? '0 : top_val;
      status    <= pend_status;
      final_res <= pend_last;
    end
  end

  `PFX_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= DEPTH_C)
  `PFX_ASSERT_NEXT(a_one_item_in_work, in_valid && in_ready, !in_ready)
  `PFX_ASSERT_NOW(a_alu_done_in_wait, alu_rsp.done, state == S_WAIT)

endmodule
`default_nettype wire

>>> verif/tb_postfix_expression_evaluator.sv
// Self-checking testbench for the postfix expression evaluator with random handshake stalls.
`timescale 1ns / 1ps
module tb_postfix_expression_evaluator;
  import pfx_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [31:0] top;
    status_t     st;
    logic        fin;
  } stack_report_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         symbol;
  logic               end_of_expr;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] top_value;
  logic [2:0]         status;
  logic               final_res;

  logic [31:0]   operand_mem [STACK_DEPTH_DEF];
  int            operand_count;
  stack_report_t due_reports [$];
  logic [7:0]    op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  int            send_gap_pct;
  int            recv_idle_pct;
  int            error_count;
  int            cycle_count;

  postfix_expression_evaluator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .top_value   (top_value),
    .status      (status),
    .final_res   (final_res)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               due_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] quot_toward_zero(logic [31:0] n, logic [31:0] d);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = n[31] ? -n : n;
    mag_d = d[31] ? -d : d;
    q = mag_n / mag_d;
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  function automatic void eval_symbol(logic [7:0] sym, logic last);
    stack_report_t rep;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   r;
    rep.st = ST_OK;
    r = '0;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (operand_count >= STACK_DEPTH_DEF) begin
        rep.st = ST_OVERFLOW;
      end else begin
        operand_mem[operand_count] = {24'd0, sym - CH_ZERO};
        operand_count++;
      end
    end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
      if (operand_count < 2) begin
        rep.st = ST_UNDERFLOW;
      end else begin
        a = operand_mem[operand_count - 1];
        b = operand_mem[operand_count - 2];
        case (sym)
          CH_PLUS: r = b + a;
          CH_MINUS: r = b - a;
          CH_STAR: r = b * a;
          default: begin
            if (a == 32'd0) begin
              rep.st = ST_DIVZERO;
            end else begin
              r = quot_toward_zero(b, a);
            end
          end
        endcase
        if (rep.st == ST_OK) begin
          operand_mem[operand_count - 2] = r;
          operand_count--;
        end
      end
    end else begin
      rep.st = ST_INVALID;
    end
    rep.top = (operand_count > 0) ? operand_mem[operand_count - 1] : 32'd0;
    rep.fin = last;
    due_reports.push_back(rep);
    if (last) begin
      operand_count = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("Mismatch at cycle %0d: %s got 0x%08h, expected 0x%08h.", cycle_count, what,
             got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    stack_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        report_mismatch("result with nothing expected, top_value", top_value, 32'd0);
      end else begin
        want = due_reports.pop_front();
        if (top_value !== want.top) begin
          report_mismatch("top_value", top_value, want.top);
        end
        if (status !== want.st) begin
          report_mismatch("status", {29'd0, status}, {29'd0, want.st});
        end
        if (final_res !== want.fin) begin
          report_mismatch("final_res", {31'd0, final_res}, {31'd0, want.fin});
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic [7:0] sym, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    symbol      <= sym;
    end_of_expr <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    eval_symbol(sym, last);
    @(negedge clk);
  endtask

  task automatic send_text(string text, bit close);
    for (int i = 0; i < text.len(); i++) begin
      send_item(text[i], close && (i == text.len() - 1));
    end
  endtask

  task automatic test_basics();
    send_text("+", 1'b0);
    send_text("9-", 1'b0);
    send_text("0/", 1'b0);
    send_text("+7-3*4/", 1'b0);
    send_text(":.", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("07-2/", 1'b1);
  endtask

  task automatic test_stack_overflow();
    send_text("98765432101234567+", 1'b1);
  endtask

  // Builds 2 * 8**10, which wraps to the most negative word, then divides it by -1.
  task automatic test_min_quotient();
    send_text("28888888888**********01-/", 1'b1);
  endtask

  task automatic test_random_exprs(int n_items);
    logic [7:0] chars [$];
    int         sent;
    int         shape;
    int         leaves;
    int         depth;
    int         n_ops;
    bit         close;
    sent = 0;
    while (sent < n_items) begin
      chars.delete();
      close = ($urandom_range(19) != 0);
      shape = $urandom_range(99);
      if (shape < 80) begin
        leaves = ($urandom_range(9) == 0) ? $urandom_range(16, 11) : $urandom_range(10, 1);
        depth = 0;
        while (leaves > 0 || depth > 1) begin
          if (leaves > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
            chars.push_back(CH_ZERO + 8'($urandom_range(9)));
            leaves--;
            depth++;
          end else begin
            chars.push_back(op_chars[$urandom_range(3)]);
            depth--;
          end
        end
        if (shape >= 70) begin
          chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255));
        end
      end else if (shape < 88) begin
        leaves = $urandom_range(19, 16);
        n_ops = $urandom_range(3);
        repeat (leaves) chars.push_back(CH_ZERO + 8'($urandom_range(9)));
        repeat (n_ops) chars.push_back(op_chars[$urandom_range(3)]);
      end
      if (chars.size() == 0) begin
        leaves = $urandom_range(6, 1);
        repeat (leaves) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += leaves;
      end else begin
        for (int i = 0; i < chars.size(); i++) begin
          send_item(chars[i], close && (i == chars.size() - 1));
        end
        sent += chars.size();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    symbol        = 8'd0;
    end_of_expr   = 1'b0;
    out_ready     = 1'b0;
    operand_count = 0;
    error_count   = 0;
    cycle_count   = 0;
    send_gap_pct  = 15;
    recv_idle_pct = 61;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basics();
    test_stack_overflow();
    test_min_quotient();
    test_random_exprs(430);
    send_gap_pct  = 61;
    recv_idle_pct = 15;
    test_random_exprs(430);
    send_gap_pct  = 0;
    recv_idle_pct = 0;
    test_random_exprs(430);
    in_valid <= 1'b0;

    while (due_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
